// ===== hdl/scs_pkg.sv =====
// Shared types and constants for the script comment strip and store block.
`default_nettype none
package scs_pkg;

	// Buffer and file table sizes.
	localparam int BUFFER_BYTES = 4096;
	localparam int SCRIPT_SLOTS = 16;
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int OFFSET_W     = ADDR_W + 1;
	localparam int SLOT_IDX_W   = $clog2(SCRIPT_SLOTS);
	localparam int SLOT_CNT_W   = SLOT_IDX_W + 1;

	// Command queue between the front and back halves.
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	// Input operation codes.
	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_BUF_FULL   = 2'd1;
	localparam logic [1:0] ERR_TABLE_FULL = 2'd2;

	// Characters the filter looks at.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Filter modes, one-hot.
	typedef enum logic [3:0] {
		MODE_SKIP_WS = 4'b0001,
		MODE_SEARCH  = 4'b0010,
		MODE_IGNORE  = 4'b0100,
		MODE_STORE   = 4'b1000
	} mode_t;

	// Work the back half carries out for one beat.
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_STORE = 2'd1,
		CMD_BEGIN = 2'd2,
		CMD_END   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// Queue status seen by the front and back halves.
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ===== hdl/scs_front.sv =====
// Front half: accepts input beats, runs the comment filter and issues commands.
`default_nettype none
module scs_front import scs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    op,
	input  wire logic [7:0]    data_byte,
	input  wire queue_status_t q_status,
	output logic               push,
	output cmd_t               push_cmd
);

	mode_t mode_q;
	mode_t mode_n;

	// Accept whenever the queue has room.
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Filter step and command classification.
	always_comb begin
		mode_t      m;
		logic [7:0] b;
		logic       keep;
		m    = mode_q;
		b    = data_byte;
		keep = 1'b0;
		push_cmd.kind = CMD_NONE;
		case (op)
			OP_DATA: begin
				if (m == MODE_SKIP_WS && b != CH_SPACE && b != CH_TAB) begin
					m = MODE_SEARCH;
				end
				if (m == MODE_SEARCH) begin
					m = (b == CH_HASH) ? MODE_IGNORE : MODE_STORE;
				end
				if (m == MODE_IGNORE && b == CH_NL) begin
					m = MODE_STORE;
				end
				if (m == MODE_STORE) begin
					if (b == CH_HASH) begin
						m = MODE_IGNORE;
					end else begin
						if (b == CH_TAB) begin
							b = CH_SPACE;
						end
						if (b != CH_CR) begin
							keep = 1'b1;
						end
						if (b == CH_NL) begin
							m = MODE_SKIP_WS;
						end
					end
				end
				if (keep) begin
					push_cmd.kind = CMD_STORE;
				end
			end
			OP_BEGIN: push_cmd.kind = CMD_BEGIN;
			OP_END:   push_cmd.kind = CMD_END;
			OP_CLEAR: m = MODE_SKIP_WS;
			default:  m = mode_q;
		endcase
		push_cmd.data = b;
		mode_n        = m;
	end

	// Filter mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP_WS;
		end else if (push) begin
			mode_q <= mode_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/scs_queue.sv =====
// Short command queue that decouples the front and back halves.
`default_nettype none
module scs_queue import scs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire cmd_t     push_cmd,
	input  wire logic     pop,
	output cmd_t          head_cmd,
	output queue_status_t status
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign head_cmd         = entry_q[rd_ptr_q];
	assign status.full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/scs_back.sv =====
// Back half: buffer offsets, file table bookkeeping and the result register.
`default_nettype none
module scs_back import scs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire queue_status_t q_status,
	input  wire cmd_t          head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               store_valid,
	output logic [7:0]         store_byte,
	output logic [ADDR_W-1:0]  store_address,
	output logic               entry_valid,
	output logic [SLOT_IDX_W-1:0] entry_slot,
	output logic [ADDR_W-1:0]  entry_offset,
	output logic [OFFSET_W-1:0] entry_length,
	output logic [OFFSET_W-1:0] free_space,
	output logic               slot_available,
	output logic [1:0]         error_flag
);

	logic [OFFSET_W-1:0]   wr_off_q;
	logic [SLOT_CNT_W-1:0] slot_cnt_q;
	logic [OFFSET_W-1:0]   file_cnt_q;
	logic [ADDR_W-1:0]     file_start_q;
	logic                  out_valid_q;

	logic [OFFSET_W-1:0]   wr_off_n;
	logic [SLOT_CNT_W-1:0] slot_cnt_n;
	logic [OFFSET_W-1:0]   file_cnt_n;
	logic [ADDR_W-1:0]     file_start_n;
	logic                  buf_full;
	logic                  table_full;
	logic                  st_valid_n;
	logic [7:0]            st_byte_n;
	logic [ADDR_W-1:0]     st_addr_n;
	logic                  en_valid_n;
	logic [1:0]            err_n;
	logic                  advance;

	// Take a command when the result register is empty or being drained.
	assign advance   = !out_valid_q || !out_stall;
	assign pop       = q_status.not_empty && advance;
	assign out_valid = out_valid_q;

	assign buf_full   = (wr_off_q >= OFFSET_W'(BUFFER_BYTES));
	assign table_full = (slot_cnt_q >= SLOT_CNT_W'(SCRIPT_SLOTS));

	// Carry out the head command.
	always_comb begin
		wr_off_n     = wr_off_q;
		slot_cnt_n   = slot_cnt_q;
		file_cnt_n   = file_cnt_q;
		file_start_n = file_start_q;
		st_valid_n   = 1'b0;
		st_byte_n    = '0;
		st_addr_n    = '0;
		en_valid_n   = 1'b0;
		err_n        = ERR_NONE;
		case (head_cmd.kind)
			CMD_STORE: begin
				if (buf_full) begin
					err_n = ERR_BUF_FULL;
				end else begin
					st_valid_n = 1'b1;
					st_byte_n  = head_cmd.data;
					st_addr_n  = wr_off_q[ADDR_W-1:0];
					wr_off_n   = wr_off_q + 1'b1;
					file_cnt_n = file_cnt_q + 1'b1;
				end
			end
			CMD_BEGIN: begin
				file_start_n = wr_off_q[ADDR_W-1:0];
				file_cnt_n   = '0;
			end
			CMD_END: begin
				if (table_full) begin
					err_n = ERR_TABLE_FULL;
				end else begin
					// Append a newline, then close the entry.
					if (buf_full) begin
						err_n = ERR_BUF_FULL;
					end else begin
						st_valid_n = 1'b1;
						st_byte_n  = CH_NL;
						st_addr_n  = wr_off_q[ADDR_W-1:0];
						wr_off_n   = wr_off_q + 1'b1;
						file_cnt_n = file_cnt_q + 1'b1;
					end
					en_valid_n = 1'b1;
					slot_cnt_n = slot_cnt_q + 1'b1;
				end
			end
			default: begin
				err_n = ERR_NONE;
			end
		endcase
	end

	// Bookkeeping state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_off_q     <= '0;
			slot_cnt_q   <= '0;
			file_cnt_q   <= '0;
			file_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				wr_off_q     <= wr_off_n;
				slot_cnt_q   <= slot_cnt_n;
				file_cnt_q   <= file_cnt_n;
				file_start_q <= file_start_n;
			end
			if (advance) begin
				out_valid_q <= pop;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (pop) begin
			store_valid    <= st_valid_n;
			store_byte     <= st_byte_n;
			store_address  <= st_addr_n;
			entry_valid    <= en_valid_n;
			entry_slot     <= en_valid_n ? slot_cnt_q[SLOT_IDX_W-1:0] : '0;
			entry_offset   <= en_valid_n ? file_start_q : '0;
			entry_length   <= en_valid_n ? file_cnt_n : '0;
			free_space     <= OFFSET_W'(BUFFER_BYTES) - wr_off_n;
			slot_available <= (slot_cnt_n < SLOT_CNT_W'(SCRIPT_SLOTS));
			error_flag     <= err_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/script_comment_strip_store.sv =====
// Top level: script comment filter feeding buffer and file table bookkeeping.
// Each accepted beat is queued, then popped into the result register and offered.
// Throughput: one item per cycle unless stalled; the four-entry command queue and
// the result register absorb short stalls; a long output stall backs up to in_stall.
// Reset (arst_n low, asynchronous): filter mode returns to skipping leading
// whitespace, buffer offset, slot count, file count and file start clear to zero.
`default_nettype none
module script_comment_strip_store import scs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             store_valid,
	output logic [7:0]       store_byte,
	output logic [11:0]      store_address,
	output logic             entry_valid,
	output logic [3:0]       entry_slot,
	output logic [11:0]      entry_offset,
	output logic [12:0]      entry_length,
	output logic [12:0]      free_space,
	output logic             slot_available,
	output logic [1:0]       error_flag
);

	queue_status_t q_status;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head_cmd;

	// Filter and classification.
	scs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Command queue.
	scs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_status)
	);

	// Buffer and table bookkeeping.
	scs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.store_valid    (store_valid),
		.store_byte     (store_byte),
		.store_address  (store_address),
		.entry_valid    (entry_valid),
		.entry_slot     (entry_slot),
		.entry_offset   (entry_offset),
		.entry_length   (entry_length),
		.free_space     (free_space),
		.slot_available (slot_available),
		.error_flag     (error_flag)
	);

	// A stored byte never carries an error.
	a_store_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_valid |-> error_flag == ERR_NONE)
		else $error("store beat flagged with an error");

	// A completed entry is never reported together with a full table.
	a_entry_not_table_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> error_flag != ERR_TABLE_FULL)
		else $error("entry completed while table full");

	// Free space never exceeds the buffer size.
	a_free_space_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> free_space <= 13'(BUFFER_BYTES))
		else $error("free space out of range");

	// The queue never takes a command while it is full.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== test/script_comment_strip_store_checker.sv =====
// Checker for the script comment strip and store block: predicts every result beat and compares it.
`default_nettype none
module script_comment_strip_store_checker import scs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  data_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        store_valid,
	input  wire logic [7:0]  store_byte,
	input  wire logic [11:0] store_address,
	input  wire logic        entry_valid,
	input  wire logic [3:0]  entry_slot,
	input  wire logic [11:0] entry_offset,
	input  wire logic [12:0] entry_length,
	input  wire logic [12:0] free_space,
	input  wire logic        slot_available,
	input  wire logic [1:0]  error_flag,
	output int               pending,
	output int               fail_count,
	output int               beats_checked,
	output int               bytes_stored,
	output int               entries_done,
	output int               overflow_drops,
	output int               table_full_ends
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result beat as the block should present it.
	typedef struct packed {
		logic        store_valid;
		logic [7:0]  store_byte;
		logic [11:0] store_address;
		logic        entry_valid;
		logic [3:0]  entry_slot;
		logic [11:0] entry_offset;
		logic [12:0] entry_length;
		logic [12:0] free_space;
		logic        slot_available;
		logic [1:0]  error_flag;
	} script_result_t;

	script_result_t expected_results[$];

	// Shadow copy of the filter and the buffer bookkeeping.
	mode_t       line_mode;
	logic [12:0] buf_used;
	logic [4:0]  slots_used;
	logic [12:0] file_len;
	logic [11:0] file_base;

	initial begin
		pending         = 0;
		fail_count      = 0;
		beats_checked   = 0;
		bytes_stored    = 0;
		entries_done    = 0;
		overflow_drops  = 0;
		table_full_ends = 0;
	end

	// Walk one text byte through the line filter; returns 1 when the byte is kept.
	function automatic bit advance_filter(input logic [7:0] ch, output logic [7:0] kept);
		bit keep;
		logic [7:0] c;
		keep = 1'b0;
		c = ch;
		kept = '0;
		if (line_mode == MODE_SKIP_WS && c != CH_SPACE && c != CH_TAB)
			line_mode = MODE_SEARCH;
		if (line_mode == MODE_SEARCH)
			line_mode = (c == CH_HASH) ? MODE_IGNORE : MODE_STORE;
		if (line_mode == MODE_IGNORE && c == CH_NL)
			line_mode = MODE_STORE;
		if (line_mode == MODE_STORE) begin
			if (c == CH_HASH) begin
				line_mode = MODE_IGNORE;
			end else begin
				if (c == CH_TAB)
					c = CH_SPACE;
				if (c != CH_CR) begin
					keep = 1'b1;
					kept = c;
				end
				if (c == CH_NL)
					line_mode = MODE_SKIP_WS;
			end
		end
		return keep;
	endfunction

	// Write one byte into the shadow buffer; returns 0 when the buffer is already full.
	function automatic bit append_byte(input logic [7:0] ch, inout script_result_t r);
		if (buf_used >= BUFFER_BYTES)
			return 1'b0;
		r.store_valid   = 1'b1;
		r.store_byte    = ch;
		r.store_address = buf_used[11:0];
		buf_used++;
		file_len++;
		return 1'b1;
	endfunction

	// Work out the result beat of one input beat and advance the shadow state.
	function automatic script_result_t strip_and_store(input logic [1:0] code,
			input logic [7:0] ch);
		script_result_t r;
		logic [7:0] kept;
		logic [1:0] err;
		r = '0;
		err = ERR_NONE;
		case (code)
			OP_DATA: begin
				if (advance_filter(ch, kept))
					if (!append_byte(kept, r))
						err = ERR_BUF_FULL;
			end
			OP_BEGIN: begin
				file_base = buf_used[11:0];
				file_len = '0;
			end
			OP_END: begin
				if (slots_used >= SCRIPT_SLOTS) begin
					err = ERR_TABLE_FULL;
				end else begin
					// The closing newline may be lost to a full buffer; the entry still closes.
					if (!append_byte(CH_NL, r))
						err = ERR_BUF_FULL;
					r.entry_valid  = 1'b1;
					r.entry_slot   = slots_used[3:0];
					r.entry_offset = file_base;
					r.entry_length = file_len;
					slots_used++;
				end
			end
			default: line_mode = MODE_SKIP_WS;
		endcase
		r.free_space     = 13'(BUFFER_BYTES) - buf_used;
		r.slot_available = (slots_used < SCRIPT_SLOTS);
		r.error_flag     = err;
		return r;
	endfunction

	function automatic int field_differs(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0d ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Compare result beats against the oldest prediction, then predict the new input beat.
	always @(posedge clk or negedge arst_n) begin
		script_result_t want;
		int bad;
		if (!arst_n) begin
			line_mode  = MODE_SKIP_WS;
			buf_used   = '0;
			slots_used = '0;
			file_len   = '0;
			file_base  = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0d ns: result beat arrived with no input beat waiting", $time);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					bad = field_differs("store_valid", want.store_valid, store_valid)
						+ field_differs("store_byte", want.store_byte, store_byte)
						+ field_differs("store_address", want.store_address, store_address)
						+ field_differs("entry_valid", want.entry_valid, entry_valid)
						+ field_differs("entry_slot", want.entry_slot, entry_slot)
						+ field_differs("entry_offset", want.entry_offset, entry_offset)
						+ field_differs("entry_length", want.entry_length, entry_length)
						+ field_differs("free_space", want.free_space, free_space)
						+ field_differs("slot_available", want.slot_available, slot_available)
						+ field_differs("error_flag", want.error_flag, error_flag);
					if (bad != 0)
						fail_count++;
					beats_checked++;
					bytes_stored    += want.store_valid;
					entries_done    += want.entry_valid;
					overflow_drops  += (want.error_flag == ERR_BUF_FULL);
					table_full_ends += (want.error_flag == ERR_TABLE_FULL);
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(strip_and_store(op, data_byte));
			pending <= expected_results.size();
		end
	end

endmodule
`default_nettype wire

// ===== test/script_comment_strip_store_tb.sv =====
// Testbench top for the script comment strip and store block: clock, reset, stimulus and verdict.
`default_nettype none
module script_comment_strip_store_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scs_pkg::*;

	localparam int RANDOM_ITEMS  = 550;
	localparam int FILL_ITEMS    = 100;
	localparam int EARLY_ENDS    = 12;
	localparam int HOLD_CYCLES   = 64;
	localparam int IDLE_LIMIT    = 1000;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic        store_valid;
	logic [7:0]  store_byte;
	logic [11:0] store_address;
	logic        entry_valid;
	logic [3:0]  entry_slot;
	logic [11:0] entry_offset;
	logic [12:0] entry_length;
	logic [12:0] free_space;
	logic        slot_available;
	logic [1:0]  error_flag;

	int pending;
	int fail_count;
	int beats_checked;
	int bytes_stored;
	int entries_done;
	int overflow_drops;
	int table_full_ends;

	int items_sent  = 0;
	int ends_sent   = 0;
	int end_budget  = EARLY_ENDS;
	int burst_left  = 0;
	int idle_cycles = 0;

	script_comment_strip_store DUT (.*);
	script_comment_strip_store_checker result_checker (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offer one beat and hold it until accepted; bursts are broken by random gaps.
	task automatic send_item(input logic [1:0] code, input logic [7:0] ch);
		// While table slots must stay free, surplus end events become mode clears.
		if (code == OP_END && ends_sent >= end_budget)
			code = OP_CLEAR;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		op        <= code;
		data_byte <= ch;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_sent++;
		if (code == OP_END)
			ends_sent++;
	endtask

	// Any operation with any byte.
	task automatic send_noise();
		send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	// A byte of line content: mostly printable, some whitespace and high bytes, never '#'.
	function automatic logic [7:0] text_char();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0: c = CH_TAB;
			1: c = CH_SPACE;
			2: c = 8'($urandom_range(8'h80, 8'hFF));
			default: begin
				c = 8'($urandom_range(8'h21, 8'h7E));
				if (c == CH_HASH)
					c = 8'h2D;
			end
		endcase
		return c;
	endfunction

	// One script line: optional indent, code or comment, optional CR, newline.
	task automatic send_line(input bit with_comments);
		int lead;
		int len;
		lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
		len = $urandom_range(0, 12);
		repeat (lead) send_item(OP_DATA, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		if (with_comments && $urandom_range(0, 5) == 0) begin
			send_item(OP_DATA, CH_HASH);
			repeat (len) send_item(OP_DATA, text_char());
		end else begin
			repeat (len) send_item(OP_DATA, text_char());
			if (with_comments && $urandom_range(0, 3) == 0) begin
				send_item(OP_DATA, CH_HASH);
				repeat ($urandom_range(0, 6)) send_item(OP_DATA, text_char());
			end
		end
		if ($urandom_range(0, 4) == 0)
			send_item(OP_DATA, CH_CR);
		send_item(OP_DATA, CH_NL);
	endtask

	// A file of several lines with stray beats mixed in; begin and end are sometimes left out.
	task automatic send_file(input int lines, input bit with_comments, input bit closed);
		if ($urandom_range(0, 7) != 0)
			send_item(OP_BEGIN, 8'($urandom_range(0, 255)));
		repeat (lines) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			send_line(with_comments);
		end
		if (closed)
			send_item(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// Receiver stall pattern, with long hold-offs that back the block up into its input.
	initial begin
		int style;
		int style_left;
		int hold_stage;
		style = 0;
		style_left = 0;
		hold_stage = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_stage < 2 && items_sent >= ((hold_stage == 0) ? 300 : 600)) begin
				hold_stage++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 300);
				end
				style_left--;
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0d ns: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int fill_start;
		int drain_cycles;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_DATA;
		data_byte = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: indent then a whole comment line, whose newline is still kept.
		send_item(OP_DATA, CH_SPACE);
		send_item(OP_DATA, CH_TAB);
		send_item(OP_DATA, CH_HASH);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, CH_NL);
		// Tab to space, dropped CR, inline comment cut short by a mode clear.
		send_item(OP_BEGIN, 8'h00);
		send_item(OP_DATA, 8'h61);
		send_item(OP_DATA, CH_TAB);
		send_item(OP_DATA, CH_CR);
		send_item(OP_DATA, CH_HASH);
		send_item(OP_DATA, 8'h78);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, CH_NL);
		send_item(OP_END, 8'h00);
		// End with no begin, then a line that opens with a carriage return.
		send_item(OP_END, 8'hFF);
		send_item(OP_BEGIN, 8'hFF);
		send_item(OP_DATA, CH_CR);
		send_item(OP_DATA, CH_NL);
		send_item(OP_END, 8'h5A);

		// Random files, keeping a few table slots for the closing phase.
		fill_start = items_sent + RANDOM_ITEMS;
		while (items_sent < fill_start)
			send_file($urandom_range(1, 8), 1'b1, $urandom_range(0, 5) != 0);

		// One long comment-free file.
		send_item(OP_BEGIN, 8'($urandom_range(0, 255)));
		fill_start = items_sent;
		while (items_sent < fill_start + FILL_ITEMS)
			send_line(1'b0);

		// Files closed until the table fills, then begin and end past that.
		end_budget = SCRIPT_SLOTS + 16;
		repeat (8) send_file($urandom_range(0, 3), 1'b1, 1'b1);
		send_item(OP_BEGIN, 8'hFF);
		send_item(OP_END, 8'h00);
		repeat (40) send_noise();
		in_valid <= 1'b0;

		// Drain the outstanding result beats.
		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (pending != 0 && drain_cycles < DRAIN_LIMIT);

		if (pending != 0) begin
			$display("%0d ns: %0d result beats never arrived", $time, pending);
			$display("Test completed with failures");
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			$display("Run summary: %0d input beats, %0d result beats checked, %0d bytes stored.",
				items_sent, beats_checked, bytes_stored);
			$display("%0d file entries completed, %0d buffer-full drops, %0d table-full ends.",
				entries_done, overflow_drops, table_full_ends);
			if (fail_count == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
